// ===== rtl/pmh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmh_pkg - peak meter shared definitions
// Types, register map, scale constants and state encodings for the meter.
// ----------------------------------------------------------------------------
package pmh_pkg;

   // defaults for top-level parameters
   localparam int unsigned METER_COUNT_DEF = 16;
   localparam int unsigned LEVEL_BITS_DEF  = 24;

   // fixed field widths
   localparam int unsigned IDX_W_IN = 4;
   localparam int unsigned AMP_W    = 24;
   localparam int unsigned BAR_W    = 8;

   // register map (word index, byte address 4*i)
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_GAIN       = 3'd0;
   localparam logic [2:0] CSR_DECAY      = 3'd1;
   localparam logic [2:0] CSR_PEAK_HOLD  = 3'd2;
   localparam logic [2:0] CSR_OVL_HOLD   = 3'd3;
   localparam logic [2:0] CSR_ACTIVE     = 3'd4;

   localparam logic [15:0] GAIN_RST      = 16'd4096;
   localparam logic [15:0] DECAY_RST     = 16'd60293;
   localparam logic [7:0]  PEAK_HOLD_RST = 8'd20;
   localparam logic [7:0]  OVL_HOLD_RST  = 8'd40;
   localparam logic [4:0]  ACTIVE_RST    = 5'd16;

   // scale
   localparam logic [BAR_W-1:0] FULL_BAR = 8'd216;
   localparam logic [7:0]       AGE_MAX  = 8'd255;
   localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd394566;  // 20*log10(2), Q16
   localparam logic [41:0] ROUND_HALF      = 42'd32768;
   localparam logic [31:0] BAR_MUL         = 32'd27;      // 216/2000 = 27/250
   localparam logic [31:0] RECIP_250       = 32'd67109;   // ceil(2^24/250)

   // attenuation breakpoints, dB in Q16
   localparam logic [31:0] ATT_70 = 32'd70 << 16;
   localparam logic [31:0] ATT_60 = 32'd60 << 16;
   localparam logic [31:0] ATT_50 = 32'd50 << 16;
   localparam logic [31:0] ATT_40 = 32'd40 << 16;
   localparam logic [31:0] ATT_30 = 32'd30 << 16;
   localparam logic [31:0] ATT_20 = 32'd20 << 16;

   // segment slopes and offsets, twentieths of a percent
   localparam logic [31:0] SLOPE_70 = 32'd5;
   localparam logic [31:0] SLOPE_60 = 32'd7;
   localparam logic [31:0] SLOPE_50 = 32'd20;
   localparam logic [31:0] SLOPE_40 = 32'd29;
   localparam logic [31:0] SLOPE_30 = 32'd39;
   localparam logic [31:0] SLOPE_20 = 32'd50;
   localparam logic [10:0] OFS_70   = 11'd0;
   localparam logic [10:0] OFS_60   = 11'd50;
   localparam logic [10:0] OFS_50   = 11'd120;
   localparam logic [10:0] OFS_40   = 11'd320;
   localparam logic [10:0] OFS_30   = 11'd610;
   localparam logic [10:0] OFS_20   = 11'd1000;

   typedef enum logic [3:0] {
      C_IDLE,
      C_DECAY,
      C_MAX,
      C_GAIN,
      C_ZCHK,
      C_NORM,
      C_MANT,
      C_SQ_MUL,
      C_SQ_ADJ,
      C_DB,
      C_ATT,
      C_SEG,
      C_SCALE,
      C_RECIP,
      C_QUOT,
      C_DONE
   } core_state_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_BUSY,
      T_COMMIT
   } top_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

endpackage

// ===== rtl/peak_meter_iec_scale_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_meter_iec_scale_hold - multi-channel IEC scale peak meter
// Per-meter decaying level, IEC bar height, held peak marker and overload.
// ----------------------------------------------------------------------------
// Sequencing: a result beat follows each accepted beat for an active meter;
//   a zero level or full scale finishes early.
// Flow: no new beat is taken until the result is committed; the 16 log2
//   squaring passes through the single shared 32x32 multiplier dominate.
// Reset: synchronous, active high; registers return to defaults, all meter
//   state clears to zero in the same cycle.
// ----------------------------------------------------------------------------
module peak_meter_iec_scale_hold
   import pmh_pkg::*;
#(
   parameter int unsigned METER_COUNT = METER_COUNT_DEF,
   parameter int unsigned LEVEL_BITS  = LEVEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request beats
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [IDX_W_IN-1:0]   req_meter_index,
   input  logic [AMP_W-1:0]      req_amplitude,
   // result beats
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_W_IN-1:0]   rsp_out_meter,
   output logic [BAR_W-1:0]      rsp_bar_height,
   output logic [BAR_W-1:0]      rsp_peak_height,
   output logic                  rsp_overload_lit,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Only 16 meter indices can be addressed, so no more storage than that.
   localparam int unsigned DEPTH = (METER_COUNT < 16) ? METER_COUNT : 16;
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [8:0]  MC    = 9'(METER_COUNT);

   // ---------------------------------------------------------------- CSRs
   logic [15:0] gain_ff;
   logic [15:0] decay_ff;
   logic [7:0]  phold_ff;
   logic [7:0]  ohold_ff;
   logic [4:0]  active_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RST;
         decay_ff  <= DECAY_RST;
         phold_ff  <= PEAK_HOLD_RST;
         ohold_ff  <= OVL_HOLD_RST;
         active_ff <= ACTIVE_RST;
      end else if (csr_wr) begin
         // writes past the last register are dropped
         unique case (csr_idx)
            CSR_GAIN:      gain_ff   <= csr_pwdata[15:0];
            CSR_DECAY:     decay_ff  <= csr_pwdata[15:0];
            CSR_PEAK_HOLD: phold_ff  <= csr_pwdata[7:0];
            CSR_OVL_HOLD:  ohold_ff  <= csr_pwdata[7:0];
            CSR_ACTIVE:    active_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_GAIN:      csr_prdata = 32'(gain_ff);
         CSR_DECAY:     csr_prdata = 32'(decay_ff);
         CSR_PEAK_HOLD: csr_prdata = 32'(phold_ff);
         CSR_OVL_HOLD:  csr_prdata = 32'(ohold_ff);
         CSR_ACTIVE:    csr_prdata = 32'(active_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // --------------------------------------------------------- meter state
   // Small per-meter register files; one meter is read and written at a time.
   logic [LEVEL_BITS-1:0] lvl_mem_ff   [DEPTH];
   logic [BAR_W-1:0]      peak_mem_ff  [DEPTH];
   logic [7:0]            page_mem_ff  [DEPTH];
   logic [7:0]            oage_mem_ff  [DEPTH];
   logic                  oflag_mem_ff [DEPTH];

   // ------------------------------------------------------- control FSM
   top_state_type         state_ff, state_in;
   logic [IDX_W_IN-1:0]   idx_ff, idx_in;
   logic                  accept;
   logic                  meter_ok;
   logic                  start;
   logic                  commit;
   logic [LEVEL_BITS-1:0] amp_aligned;
   logic [AMP_W+LEVEL_BITS-1:0] amp_wide;
   logic [LEVEL_BITS-1:0] level_old;
   logic [LEVEL_BITS-1:0] level_new;
   logic [BAR_W-1:0]      bar;
   core_sts_type          core_sts;

   // Q1.23 to Q1.(LEVEL_BITS-1): widen by LEVEL_BITS, drop 24, truncating
   assign amp_wide    = {req_amplitude, {LEVEL_BITS{1'b0}}};
   assign amp_aligned = amp_wide[AMP_W+LEVEL_BITS-1:AMP_W];

   // inactive meters give no result and touch nothing
   assign meter_ok = ({1'b0, req_meter_index} < active_ff) &&
                     ({5'd0, req_meter_index} < MC);
   assign accept   = req_valid && req_ready;
   assign start    = accept && meter_ok;
   assign level_old = lvl_mem_ff[req_meter_index[IDX_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      commit    = 1'b0;
      req_ready = (state_ff == T_IDLE) && !core_sts.busy;

      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               idx_in   = req_meter_index;
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (core_sts.done) begin
               state_in = T_COMMIT;
            end
         end
         T_COMMIT: begin
            // wait for a free result register before updating state
            if (!rsp_valid || rsp_ready) begin
               commit   = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   pmh_bar_core #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .level_old    (level_old),
      .amp_aligned  (amp_aligned),
      .decay_factor (decay_ff),
      .gain         (gain_ff),
      .level_new    (level_new),
      .bar_height   (bar),
      .sts          (core_sts)
   );

   // --------------------------------------------------- hold and overload
   logic [IDX_W-1:0] widx;
   logic [BAR_W-1:0] hp, hp_n;
   logic [7:0]       pa, pa_n;
   logic [7:0]       oa, oa_n;
   logic             of, of_n;

   assign widx = idx_ff[IDX_W-1:0];
   assign hp   = peak_mem_ff[widx];
   assign pa   = page_mem_ff[widx];
   assign oa   = oage_mem_ff[widx];
   assign of   = oflag_mem_ff[widx];

   always_comb begin
      // rising bar grabs the marker; otherwise it follows once hold expires
      if (bar > hp) begin
         hp_n = bar;
         pa_n = '0;
      end else begin
         hp_n = (pa > phold_ff) ? bar : hp;
         pa_n = (pa != AGE_MAX) ? pa + 8'd1 : pa;
      end
      // full scale lights overload and restarts its hold
      if (bar >= FULL_BAR) begin
         of_n = 1'b1;
         oa_n = '0;
      end else begin
         of_n = (oa > ohold_ff) ? 1'b0 : of;
         oa_n = (oa != AGE_MAX) ? oa + 8'd1 : oa;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            lvl_mem_ff[i]   <= '0;
            peak_mem_ff[i]  <= '0;
            page_mem_ff[i]  <= '0;
            oage_mem_ff[i]  <= '0;
            oflag_mem_ff[i] <= 1'b0;
         end
      end else if (commit) begin
         lvl_mem_ff[widx]   <= level_new;
         peak_mem_ff[widx]  <= hp_n;
         page_mem_ff[widx]  <= pa_n;
         oage_mem_ff[widx]  <= oa_n;
         oflag_mem_ff[widx] <= of_n;
      end
   end

   // ------------------------------------------------------- result beat
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W_IN-1:0] rsp_meter_ff;
   logic [BAR_W-1:0]    rsp_bar_ff;
   logic [BAR_W-1:0]    rsp_peak_ff;
   logic                rsp_ovl_ff;

   assign rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_meter_ff <= idx_ff;
         rsp_bar_ff   <= bar;
         rsp_peak_ff  <= hp_n;
         rsp_ovl_ff   <= of_n;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_meter    = rsp_meter_ff;
   assign rsp_bar_height   = rsp_bar_ff;
   assign rsp_peak_height  = rsp_peak_ff;
   assign rsp_overload_lit = rsp_ovl_ff;

endmodule

// ===== rtl/pmh_bar_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmh_bar_core - level update and bar height sequencer
// Decays the level, applies gain, takes log2 and maps dB to bar height,
// all on one shared 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module pmh_bar_core
   import pmh_pkg::*;
#(
   parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [LEVEL_BITS-1:0] level_old,
   input  logic [LEVEL_BITS-1:0] amp_aligned,
   input  logic [15:0]           decay_factor,
   input  logic [15:0]           gain,
   output logic [LEVEL_BITS-1:0] level_new,
   output logic [BAR_W-1:0]      bar_height,
   output core_sts_type          sts
);

   localparam int unsigned PW    = LEVEL_BITS + 16;
   localparam int unsigned NW    = (PW < 31) ? 31 : PW;
   localparam int unsigned LZ_W  = $clog2(NW);
   localparam int unsigned LG_W  = LZ_W + 16;
   localparam int unsigned A_W   = 26;
   localparam logic [LG_W-1:0] REF_LG = LG_W'((LEVEL_BITS + 11) * 65536);

   core_state_type state_ff, state_in;

   logic [63:0]           prod_ff, prod_in;
   logic [31:0]           mul_a, mul_b;
   logic [LEVEL_BITS-1:0] lvl_ff, lvl_in;
   logic [LEVEL_BITS-1:0] amp_ff, amp_in;
   logic [NW-1:0]         norm_ff, norm_in;
   logic [LZ_W-1:0]       lz_ff, lz_in;
   logic [3:0]            step_ff, step_in;
   logic [30:0]           m_ff, m_in;
   logic [15:0]           frac_ff, frac_in;
   logic [A_W-1:0]        a_ff, a_in;
   logic [10:0]           o_ff, o_in;
   logic [BAR_W-1:0]      bar_ff, bar_in;

   logic [LEVEL_BITS-1:0] decayed;
   logic [LZ_W-1:0]       sh_amt;
   logic [NW-1:0]         top_mask;
   logic [31:0]           sq;
   logic [LZ_W-1:0]       e_val;
   logic [LG_W-1:0]       lg;
   logic [41:0]           a_sum;
   logic [26:0]           v_val;
   logic [15:0]           q_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      lvl_ff  <= lvl_in;
      amp_ff  <= amp_in;
      norm_ff <= norm_in;
      lz_ff   <= lz_in;
      step_ff <= step_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      a_ff    <= a_in;
      o_ff    <= o_in;
      bar_ff  <= bar_in;
   end

   // shared multiplier
   assign prod_in = mul_a * mul_b;

   assign decayed  = prod_ff[LEVEL_BITS+15:16];
   assign sh_amt   = LZ_W'(1) << (LZ_W'(LZ_W - 1) - LZ_W'(step_ff));
   assign top_mask = ~({NW{1'b1}} >> sh_amt);
   assign sq       = prod_ff[61:30];
   assign e_val    = LZ_W'(NW - 1) - lz_ff;
   assign lg       = {e_val, frac_ff};
   assign a_sum    = prod_ff[41:0] + ROUND_HALF;
   assign v_val    = prod_ff[26:0] + {o_ff, 16'd0};
   assign q_val    = prod_ff[39:24];

   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      amp_in   = amp_ff;
      norm_in  = norm_ff;
      lz_in    = lz_ff;
      step_in  = step_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      a_in     = a_ff;
      o_in     = o_ff;
      bar_in   = bar_ff;
      mul_a    = '0;
      mul_b    = '0;
      sts.busy = (state_ff != C_IDLE);
      sts.done = 1'b0;

      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               lvl_in   = level_old;
               amp_in   = amp_aligned;
               state_in = C_DECAY;
            end
         end
         C_DECAY: begin
            mul_a    = 32'(lvl_ff);
            mul_b    = 32'(decay_factor);
            state_in = C_MAX;
         end
         C_MAX: begin
            lvl_in   = (amp_ff > decayed) ? amp_ff : decayed;
            state_in = C_GAIN;
         end
         C_GAIN: begin
            mul_a    = 32'(lvl_ff);
            mul_b    = 32'(gain);
            state_in = C_ZCHK;
         end
         C_ZCHK: begin
            // zero level or gain: minus infinity dB
            if (prod_ff[PW-1:0] == '0) begin
               bar_in   = '0;
               state_in = C_DONE;
            end else begin
               norm_in  = NW'(prod_ff[PW-1:0]);
               lz_in    = '0;
               step_in  = '0;
               state_in = C_NORM;
            end
         end
         C_NORM: begin
            // binary leading-zero search, widest step first
            if ((norm_ff & top_mask) == '0) begin
               norm_in = norm_ff << sh_amt;
               lz_in   = lz_ff + sh_amt;
            end
            if (step_ff == 4'(LZ_W - 1)) begin
               state_in = C_MANT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         C_MANT: begin
            m_in     = norm_ff[NW-1 -: 31];
            frac_in  = '0;
            step_in  = '0;
            state_in = C_SQ_MUL;
         end
         C_SQ_MUL: begin
            mul_a    = 32'(m_ff);
            mul_b    = 32'(m_ff);
            state_in = C_SQ_ADJ;
         end
         C_SQ_ADJ: begin
            if (sq[31]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               m_in    = sq[31:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               m_in    = sq[30:0];
            end
            if (step_ff == 4'd15) begin
               state_in = C_DB;
            end else begin
               step_in  = step_ff + 4'd1;
               state_in = C_SQ_MUL;
            end
         end
         C_DB: begin
            if (lg >= REF_LG) begin
               bar_in   = FULL_BAR;
               state_in = C_DONE;
            end else begin
               mul_a    = 32'(REF_LG - lg);
               mul_b    = DB_PER_LOG2_Q16;
               state_in = C_ATT;
            end
         end
         C_ATT: begin
            a_in     = a_sum[41:16];
            state_in = C_SEG;
         end
         C_SEG: begin
            state_in = C_SCALE;
            priority if (32'(a_ff) > ATT_70) begin
               bar_in   = '0;
               state_in = C_DONE;
            end else if (32'(a_ff) > ATT_60) begin
               mul_a = ATT_70 - 32'(a_ff);
               mul_b = SLOPE_70;
               o_in  = OFS_70;
            end else if (32'(a_ff) > ATT_50) begin
               mul_a = ATT_60 - 32'(a_ff);
               mul_b = SLOPE_60;
               o_in  = OFS_60;
            end else if (32'(a_ff) > ATT_40) begin
               mul_a = ATT_50 - 32'(a_ff);
               mul_b = SLOPE_50;
               o_in  = OFS_50;
            end else if (32'(a_ff) > ATT_30) begin
               mul_a = ATT_40 - 32'(a_ff);
               mul_b = SLOPE_40;
               o_in  = OFS_40;
            end else if (32'(a_ff) > ATT_20) begin
               mul_a = ATT_30 - 32'(a_ff);
               mul_b = SLOPE_30;
               o_in  = OFS_30;
            end else begin
               mul_a = ATT_20 - 32'(a_ff);
               mul_b = SLOPE_20;
               o_in  = OFS_20;
            end
         end
         C_SCALE: begin
            mul_a    = 32'(v_val);
            mul_b    = BAR_MUL;
            state_in = C_RECIP;
         end
         C_RECIP: begin
            // divide by 250 through the reciprocal, exact for 16-bit input
            mul_a    = 32'(prod_ff[31:16]);
            mul_b    = RECIP_250;
            state_in = C_QUOT;
         end
         C_QUOT: begin
            bar_in   = (q_val > 16'(FULL_BAR)) ? FULL_BAR : q_val[BAR_W-1:0];
            state_in = C_DONE;
         end
         C_DONE: begin
            sts.done = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   assign level_new  = lvl_ff;
   assign bar_height = bar_ff;

endmodule
